// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level of the range header parser
// expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/hrhp_pkg.sv =====
// shared types, constants and helpers of the http range header parser
// no dependencies; used by the channel interface, the number reader and the top level
package hrhp_pkg;

   localparam int unsigned PREFIX_LEN = 6;

   localparam logic [7:0] DASH_CHAR = 8'h2d;
   localparam logic [7:0] PLUS_CHAR = 8'h2b;

   // magnitude bound for signed 64-bit, and its tenth
   localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAG_DIV10 = 64'd922337203685477580;
   localparam logic [3:0]  MAG_MOD10 = 4'd8;

   localparam logic [1:0] OUTCOME_FULL      = 2'd0;
   localparam logic [1:0] OUTCOME_OFFSET    = 2'd1;
   localparam logic [1:0] OUTCOME_MALFORMED = 2'd2;

   typedef enum logic [1:0] {
      PH_BLANK,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic        negative;
      logic [63:0] magnitude;
      logic        overflow;
   } reader_type;

   localparam reader_type READER_CLEAR = '{
      phase:     PH_BLANK,
      negative:  1'b0,
      magnitude: 64'd0,
      overflow:  1'b0
   };

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_value;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] start_offset;
      logic [63:0] end_limit;
      logic [1:0]  outcome;
   } rsp_payload_type;

   // expected byte of "bytes=" at a prefix position
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h62;
         3'd1:    c = 8'h79;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h65;
         3'd4:    c = 8'h73;
         3'd5:    c = 8'h3d;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // space, tab, lf, vt, ff, cr
   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

endpackage

// ===== hw/rtl/hrhp_chan_if.sv =====
// valid/ready channel carrying one payload struct per transfer
// payload types come from hrhp_pkg
interface hrhp_chan_if #(
   parameter type payload_type = hrhp_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/http_range_header_parser_core.sv =====
// top level of the http range header parser: byte input, one result per header value
// depends on hrhp_pkg, hrhp_chan_if, hrhp_num_reader and assert_macros.svh
//
// The header value (for example "bytes=100-199") streams in one byte per
// transfer on req_chan, with end_of_value set on its final byte. A new byte
// can be taken every clock cycle, but a final byte waits for room in the
// snapshot stage; the figure is set by the per-byte multiply-by-ten accumulate
// of the two number readers, done combinationally as shift-and-add. After the
// final byte the result (start_offset, end_limit, outcome) passes the input
// register and the snapshot, value and compare stages to rsp_chan, and bytes
// of the next header value may follow the final byte at once. Outcome 0 is a
// full range, 1 an offset only (end_limit zero), 2 malformed (both numbers zero).
`include "assert_macros.svh"

module http_range_header_parser_core (
   input logic        clock,
   input logic        reset,
   hrhp_chan_if.sink  req_chan,
   hrhp_chan_if.source rsp_chan
);

   // final snapshot taken on the last byte of a value
   typedef struct packed {
      logic                 prefix_ok;
      logic                 dash;
      logic                 after;
      hrhp_pkg::reader_type first;
      hrhp_pkg::reader_type second;
   } fin_type;

   // signed values and range checks, ready for the final compare
   typedef struct packed {
      logic        malformed;
      logic        short_range;
      logic [63:0] first_val;
      logic [63:0] second_val;
   } val_type;

   // input register
   logic                      in_valid_ff;
   hrhp_pkg::req_payload_type in_ff;

   // value-level parse state
   logic [2:0] pos_ff,    pos_in;
   logic       failed_ff, failed_in;
   logic       dash_ff,   dash_in;
   logic       after_ff,  after_in;

   // pipeline after the state update
   logic                      s1_valid_ff;
   fin_type                   s1_ff;
   logic                      s2_valid_ff;
   val_type                   s2_ff, s2_in;
   logic                      rsp_valid_ff;
   hrhp_pkg::rsp_payload_type rsp_ff, rsp_in;

   // handshake flow, each stage moves when the one after it has room
   logic rsp_free, s2_free, s1_free, in_take, in_free, in_last;

   logic                 in_prefix_done;
   logic                 feed_first, feed_second, clear_readers;
   hrhp_pkg::reader_type first_next, second_next;
   logic                 first_oor, second_oor;

   assign in_last  = in_ff.end_of_value;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign s2_free  = !s2_valid_ff || rsp_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   // a non-final byte only updates state, a final one needs room for its snapshot
   assign in_take  = in_valid_ff && (!in_last || s1_free);
   assign in_free  = !in_valid_ff || in_take;

   assign req_chan.ready   = in_free;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_chan.valid;
      end
      if (in_free && req_chan.valid) begin
         in_ff <= req_chan.payload;
      end
   end

   // prefix match, then dash search; a failed prefix freezes everything
   assign in_prefix_done = (pos_ff == 3'(hrhp_pkg::PREFIX_LEN));
   assign feed_first     = in_take && in_prefix_done && !failed_ff;
   assign feed_second    = feed_first && dash_ff;
   assign clear_readers  = in_take && in_last;

   always_comb begin
      pos_in    = pos_ff;
      failed_in = failed_ff;
      dash_in   = dash_ff;
      after_in  = after_ff;
      if (in_take) begin
         if (!in_prefix_done) begin
            if (!failed_ff) begin
               if (in_ff.char_byte == hrhp_pkg::prefix_char(pos_ff)) pos_in = pos_ff + 3'd1;
               else                                                 failed_in = 1'b1;
            end
         end else if (!failed_ff) begin
            if (dash_ff) begin
               after_in = 1'b1;
            end else if (in_ff.char_byte == hrhp_pkg::DASH_CHAR) begin
               dash_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_readers) begin
         pos_ff    <= 3'd0;
         failed_ff <= 1'b0;
         dash_ff   <= 1'b0;
         after_ff  <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         failed_ff <= failed_in;
         dash_ff   <= dash_in;
         after_ff  <= after_in;
      end
   end

   // first number from just after the prefix, second from just after the dash
   hrhp_num_reader u_first (
      .clock     (clock),
      .reset     (reset),
      .feed      (feed_first),
      .clear     (clear_readers),
      .char_byte (in_ff.char_byte),
      .rd_next   (first_next)
   );

   hrhp_num_reader u_second (
      .clock     (clock),
      .reset     (reset),
      .feed      (feed_second),
      .clear     (clear_readers),
      .char_byte (in_ff.char_byte),
      .rd_next   (second_next)
   );

   // snapshot stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= in_take && in_last;
      end
      if (in_take && in_last) begin
         s1_ff.prefix_ok <= (pos_in == 3'(hrhp_pkg::PREFIX_LEN)) && !failed_in;
         s1_ff.dash      <= dash_in;
         s1_ff.after     <= after_in;
         s1_ff.first     <= first_next;
         s1_ff.second    <= second_next;
      end
   end

   // value stage: range checks and sign applied
   assign first_oor  = s1_ff.first.overflow ||
                       (!s1_ff.first.negative && s1_ff.first.magnitude == hrhp_pkg::MAG_LIMIT);
   assign second_oor = s1_ff.second.overflow ||
                       (!s1_ff.second.negative &&
                        s1_ff.second.magnitude == hrhp_pkg::MAG_LIMIT);

   always_comb begin
      s2_in.malformed   = !s1_ff.prefix_ok || !s1_ff.dash || first_oor;
      s2_in.short_range = !s1_ff.after || second_oor;
      s2_in.first_val   = s1_ff.first.negative ? (64'd0 - s1_ff.first.magnitude)
                                               : s1_ff.first.magnitude;
      s2_in.second_val  = s1_ff.second.negative ? (64'd0 - s1_ff.second.magnitude)
                                                : s1_ff.second.magnitude;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_free && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   // compare stage: unsigned order check, outcome select
   always_comb begin
      rsp_in.start_offset = s2_ff.first_val;
      rsp_in.end_limit    = 64'd0;
      rsp_in.outcome      = hrhp_pkg::OUTCOME_OFFSET;
      if (s2_ff.malformed) begin
         rsp_in.start_offset = 64'd0;
         rsp_in.outcome      = hrhp_pkg::OUTCOME_MALFORMED;
      end else if (!s2_ff.short_range && !(s2_ff.second_val < s2_ff.first_val)) begin
         rsp_in.end_limit = s2_ff.second_val;
         rsp_in.outcome   = hrhp_pkg::OUTCOME_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (rsp_free && s2_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // checks on the result rules and the final-byte path
   `ASSERT_IMPL(a_limit_zero, rsp_valid_ff && rsp_ff.outcome != hrhp_pkg::OUTCOME_FULL, rsp_ff.end_limit == 64'd0, "end_limit nonzero without full range")
   `ASSERT_IMPL(a_malformed_zero, rsp_valid_ff && rsp_ff.outcome == hrhp_pkg::OUTCOME_MALFORMED, rsp_ff.start_offset == 64'd0, "start_offset nonzero on malformed value")
   `ASSERT_IMPL(a_full_order, rsp_valid_ff && rsp_ff.outcome == hrhp_pkg::OUTCOME_FULL, rsp_ff.end_limit >= rsp_ff.start_offset, "full range with limit below offset")
   `ASSERT_NEXT(a_final_snapshot, in_take && in_last, s1_valid_ff && pos_ff == 3'd0 && !dash_ff, "final byte did not reach snapshot or state not cleared")

endmodule

// ===== hw/rtl/hrhp_num_reader.sv =====
// strtol-style decimal reader: blanks, optional sign, digits, 64-bit overflow
// depends on hrhp_pkg (reader_type, phase codes, bounds)
module hrhp_num_reader (
   input  logic                clock,
   input  logic                reset,
   input  logic                feed,
   input  logic                clear,
   input  logic [7:0]          char_byte,
   output hrhp_pkg::reader_type rd_next
);

   hrhp_pkg::reader_type rd_ff;
   hrhp_pkg::reader_type rd_calc;

   logic        is_digit;
   logic [3:0]  digit_val;
   logic        acc_big;
   logic [63:0] acc_mag;

   assign is_digit  = char_byte inside {[8'h30:8'h39]};
   assign digit_val = char_byte[3:0];

   // times ten as two shifts and an add
   assign acc_big = (rd_ff.magnitude > hrhp_pkg::MAG_DIV10) ||
                    (rd_ff.magnitude == hrhp_pkg::MAG_DIV10 &&
                     digit_val > hrhp_pkg::MAG_MOD10);
   assign acc_mag = (rd_ff.magnitude << 3) + (rd_ff.magnitude << 1) +
                    {60'd0, digit_val};

   always_comb begin
      rd_calc = rd_ff;
      case (rd_ff.phase)
         hrhp_pkg::PH_BLANK: begin
            if (hrhp_pkg::is_blank(char_byte)) begin
               rd_calc.phase = hrhp_pkg::PH_BLANK;
            end else if (char_byte == hrhp_pkg::PLUS_CHAR ||
                         char_byte == hrhp_pkg::DASH_CHAR) begin
               rd_calc.negative = (char_byte == hrhp_pkg::DASH_CHAR);
               rd_calc.phase    = hrhp_pkg::PH_SIGN;
            end else if (is_digit) begin
               rd_calc.phase = hrhp_pkg::PH_DIGITS;
               if (!rd_ff.overflow) begin
                  if (acc_big) rd_calc.overflow = 1'b1;
                  else         rd_calc.magnitude = acc_mag;
               end
            end else begin
               rd_calc.phase = hrhp_pkg::PH_DONE;
            end
         end
         hrhp_pkg::PH_SIGN, hrhp_pkg::PH_DIGITS: begin
            if (is_digit) begin
               rd_calc.phase = hrhp_pkg::PH_DIGITS;
               if (!rd_ff.overflow) begin
                  if (acc_big) rd_calc.overflow = 1'b1;
                  else         rd_calc.magnitude = acc_mag;
               end
            end else begin
               rd_calc.phase = hrhp_pkg::PH_DONE;
            end
         end
         default: begin
            rd_calc = rd_ff;
         end
      endcase
   end

   assign rd_next = feed ? rd_calc : rd_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         rd_ff <= hrhp_pkg::READER_CLEAR;
      end else begin
         rd_ff <= rd_next;
      end
   end

endmodule

// ===== sim/tb.sv =====
// self-checking testbench of http_range_header_parser_core
// depends on hrhp_pkg, hrhp_chan_if and the rtl top level; drives header bytes, checks each range

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // predicts the range result of each header value and holds those still due
   class range_scoreboard;
      hrhp_pkg::rsp_payload_type expected_ranges[$];
      int                        errors;
      int                        prefix_pos;
      bit                        prefix_bad;
      bit                        dash_found;
      bit                        past_dash;
      hrhp_pkg::reader_type      lead_reader;
      hrhp_pkg::reader_type      tail_reader;
      string                     prefix_text = "bytes=";

      function void clear_parse();
         prefix_pos  = 0;
         prefix_bad  = 0;
         dash_found  = 0;
         past_dash   = 0;
         lead_reader = '{phase: hrhp_pkg::PH_BLANK, negative: 1'b0, magnitude: 64'd0,
                         overflow: 1'b0};
         tail_reader = lead_reader;
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("%0t: %s", $realtime, what);
      endfunction

      function hrhp_pkg::reader_type add_digit(hrhp_pkg::reader_type r, logic [3:0] d);
         if (r.overflow) return r;
         if (r.magnitude > hrhp_pkg::MAG_DIV10 ||
             (r.magnitude == hrhp_pkg::MAG_DIV10 && d > hrhp_pkg::MAG_MOD10))
            r.overflow = 1'b1;
         else
            r.magnitude = r.magnitude * 10 + 64'(d);
         return r;
      endfunction

      function hrhp_pkg::reader_type read_char(hrhp_pkg::reader_type r, logic [7:0] c);
         logic is_digit;
         logic is_space;
         is_digit = (c >= 8'h30) && (c <= 8'h39);
         is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b)
                    || (c == 8'h0c) || (c == 8'h0d);
         case (r.phase)
            hrhp_pkg::PH_BLANK: begin
               if (is_space) begin
               end else if (c == hrhp_pkg::PLUS_CHAR || c == hrhp_pkg::DASH_CHAR) begin
                  r.negative = (c == hrhp_pkg::DASH_CHAR);
                  r.phase    = hrhp_pkg::PH_SIGN;
               end else if (is_digit) begin
                  r.phase = hrhp_pkg::PH_DIGITS;
                  r = add_digit(r, c[3:0]);
               end else begin
                  r.phase = hrhp_pkg::PH_DONE;
               end
            end
            hrhp_pkg::PH_SIGN, hrhp_pkg::PH_DIGITS: begin
               if (is_digit) begin
                  r.phase = hrhp_pkg::PH_DIGITS;
                  r = add_digit(r, c[3:0]);
               end else begin
                  r.phase = hrhp_pkg::PH_DONE;
               end
            end
            default: begin
            end
         endcase
         return r;
      endfunction

      function bit out_of_range(hrhp_pkg::reader_type r);
         return r.overflow || (!r.negative && r.magnitude == hrhp_pkg::MAG_LIMIT);
      endfunction

      function logic [63:0] signed_pattern(hrhp_pkg::reader_type r);
         return r.negative ? (64'd0 - r.magnitude) : r.magnitude;
      endfunction

      function void note_byte(logic [7:0] c, logic last);
         hrhp_pkg::rsp_payload_type r;
         logic [63:0]               a;
         logic [63:0]               b;
         if (prefix_pos < hrhp_pkg::PREFIX_LEN) begin
            if (!prefix_bad) begin
               if (c == prefix_text[prefix_pos]) prefix_pos++;
               else prefix_bad = 1;
            end
         end else if (!prefix_bad) begin
            lead_reader = read_char(lead_reader, c);
            if (dash_found) begin
               past_dash   = 1;
               tail_reader = read_char(tail_reader, c);
            end else if (c == hrhp_pkg::DASH_CHAR) begin
               dash_found = 1;
            end
         end
         if (!last) return;
         r = '{start_offset: 64'd0, end_limit: 64'd0, outcome: hrhp_pkg::OUTCOME_MALFORMED};
         if (!(prefix_bad || prefix_pos < hrhp_pkg::PREFIX_LEN || !dash_found
               || out_of_range(lead_reader))) begin
            a = signed_pattern(lead_reader);
            b = signed_pattern(tail_reader);
            r.start_offset = a;
            if (!past_dash || out_of_range(tail_reader) || b < a) begin
               r.outcome = hrhp_pkg::OUTCOME_OFFSET;
            end else begin
               r.outcome   = hrhp_pkg::OUTCOME_FULL;
               r.end_limit = b;
            end
         end
         expected_ranges.push_back(r);
         clear_parse();
      endfunction

      function void check_range(hrhp_pkg::rsp_payload_type got);
         hrhp_pkg::rsp_payload_type want;
         if (expected_ranges.size() == 0) begin
            flag($sformatf("unexpected result offset=%h limit=%h outcome=%0d",
                           got.start_offset, got.end_limit, got.outcome));
            return;
         end
         want = expected_ranges.pop_front();
         if (got.start_offset !== want.start_offset)
            flag($sformatf("start_offset expected %h actual %h",
                           want.start_offset, got.start_offset));
         if (got.end_limit !== want.end_limit)
            flag($sformatf("end_limit expected %h actual %h", want.end_limit, got.end_limit));
         if (got.outcome !== want.outcome)
            flag($sformatf("outcome expected %0d actual %0d", want.outcome, got.outcome));
      endfunction

      function int pending();
         return expected_ranges.size();
      endfunction

      function void close_out();
         if (expected_ranges.size() != 0)
            flag($sformatf("%0d results never arrived", expected_ranges.size()));
      endfunction
   endclass

   logic clock;
   logic reset;

   hrhp_chan_if #(.payload_type(hrhp_pkg::req_payload_type)) req_chan ();
   hrhp_chan_if #(.payload_type(hrhp_pkg::rsp_payload_type)) rsp_chan ();

   http_range_header_parser_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   range_scoreboard sb;
   logic [7:0]      header_bytes[$];
   bit              calm;
   int              bytes_sent;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function void add_text(string s);
      for (int i = 0; i < s.len(); i++) header_bytes.push_back(s[i]);
   endfunction

   function void add_byte(logic [7:0] b);
      header_bytes.push_back(b);
   endfunction

   // one transfer on the byte channel, with random idle cycles ahead of it unless calm is set
   task automatic send_byte(input logic [7:0] c, input logic last);
      while (!calm && $urandom_range(99) < 36) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{char_byte: c, end_of_value: last};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_byte(c, last);
      bytes_sent++;
   endtask

   task automatic send_header();
      logic [7:0] c;
      while (header_bytes.size() != 0) begin
         c = header_bytes.pop_front();
         send_byte(c, header_bytes.size() == 0);
      end
   endtask

   function logic [63:0] rand_magnitude();
      case ($urandom_range(3))
         0:       return 64'($urandom_range(9));
         1:       return 64'($urandom_range(99999));
         2:       return {$urandom, $urandom} >> $urandom_range(1, 63);
         default: return 64'($urandom);
      endcase
   endfunction

   // optional blanks and sign, then digits from a magnitude or an edge string, or no digits at all
   function void add_number(logic [63:0] m, bit allow_sign);
      string edge_nums[7];
      edge_nums = '{"9223372036854775807", "9223372036854775808", "9223372036854775809",
                   "18446744073709551615", "99999999999999999999", "0000000000000000000042",
                   "922337203685477581"};
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(5))
               0: add_byte(8'h20);
               1: add_byte(8'h09);
               2: add_byte(8'h0a);
               3: add_byte(8'h0b);
               4: add_byte(8'h0c);
               default: add_byte(8'h0d);
            endcase
         end
      end
      if (allow_sign && $urandom_range(99) < 20)
         add_byte($urandom_range(1) ? hrhp_pkg::PLUS_CHAR : hrhp_pkg::DASH_CHAR);
      case ($urandom_range(19))
         0:       begin end
         1, 2:    add_text(edge_nums[$urandom_range(6)]);
         default: add_text($sformatf("%0d", m));
      endcase
   endfunction

   function void build_random_header();
      int          kind;
      logic [63:0] a;
      logic [63:0] b;
      kind = $urandom_range(99);
      if (kind < 70) begin
         a = rand_magnitude();
         b = $urandom_range(1) ? a + 64'($urandom_range(1000)) : rand_magnitude();
         add_text("bytes=");
         add_number(a, 1);
         if ($urandom_range(99) < 92) add_byte(hrhp_pkg::DASH_CHAR);
         if ($urandom_range(99) < 85) add_number(b, $urandom_range(1) != 0);
         if ($urandom_range(99) < 10) add_byte(8'($urandom_range(255)));
      end else if (kind < 85) begin
         // noise, sometimes behind a good prefix
         if ($urandom_range(1)) add_text("bytes=");
         repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
      end else begin
         // damaged prefix or junk inside the numbers
         add_text("bytes=");
         if ($urandom_range(1)) begin
            header_bytes[$urandom_range(5)] = 8'($urandom_range(255));
         end else begin
            repeat ($urandom_range(5)) void'(header_bytes.pop_back());
         end
         add_text($sformatf("%0d", rand_magnitude()));
         if ($urandom_range(1)) add_byte(8'($urandom_range(255)));
         add_byte(hrhp_pkg::DASH_CHAR);
         add_text($sformatf("%0d", rand_magnitude()));
         if (header_bytes.size() == 0) add_byte(8'($urandom_range(255)));
      end
   endfunction

   // result side: random stalls, check on every transfer
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) sb.check_range(rsp_chan.payload);
         rsp_chan.ready <= calm || ($urandom_range(99) >= 36);
      end
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int guard;
      int hdr_count;
      sb = new();
      sb.clear_parse();
      calm       = 0;
      bytes_sent = 0;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed values
      add_text("bytes=100-199");                       send_header();
      add_text("bytes=100-");                          send_header();
      add_text("bytes=200-100");                       send_header();
      add_text("byte");                                send_header();
      add_text("bytes:1-2");                           send_header();
      add_text("bytes=100");                           send_header();
      add_text("bytes=9223372036854775808-");          send_header();
      add_text("bytes=-9223372036854775808-5");        send_header();
      add_text("bytes=0-9223372036854775807");         send_header();
      add_text("bytes=1-9223372036854775808");         send_header();
      add_text("bytes=99999999999999999999-1");        send_header();
      add_text("bytes=-5");                            send_header();
      add_text("bytes= \t+42-\n\v\f\r43");             send_header();
      add_text("bytes=--");                            send_header();
      add_text("bytes=+-");                            send_header();
      add_text("bytes=12a-34x");                       send_header();
      add_text("bytes=1-");  add_byte(8'h00);          send_header();
      add_byte(8'h00);                                 send_header();
      add_byte(8'hff);                                 send_header();
      add_text("bytes="); add_byte(8'hff); add_text("-7"); send_header();
      add_text("bytes=7-7");                           send_header();
      add_text("bytes-1-2");                           send_header();

      // hold the sender until every result is out
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);

      hdr_count = 0;
      while (bytes_sent < 1500) begin
         calm = (hdr_count >= 30 && hdr_count < 70);
         build_random_header();
         send_header();
         hdr_count++;
      end
      calm = 0;
      req_chan.valid <= 1'b0;

      guard = 0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (12) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
